>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands sampled on clk, switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rstd_pkg.sv
// ---------------------------------------------------------------------------
// rstd_pkg
// Types and sizes shared by the rate-shaped task dispatcher.
// ---------------------------------------------------------------------------
package rstd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  // time sums carry one extra bit, differences one more for the sign
  localparam int ACC_W       = TIME_WIDTH + 2;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_REMOVE  = 2'd1,
    FUNC_DECIDE  = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [ID_WIDTH-1:0]   task_id;
    logic [TIME_WIDTH-1:0] now;
    logic                  busy_req;
  } task_word_t;

  typedef struct packed {
    logic                  assigned;
    logic [ID_WIDTH-1:0]   assigned_task;
    logic                  slice_valid;
    logic [TIME_WIDTH-1:0] slice_time;
    logic                  dropped;
    logic                  found;
    logic [CNT_W-1:0]      queue_count;
  } rsp_word_t;

endpackage

>>> src/rate_shaped_task_dispatcher_top.sv
// ---------------------------------------------------------------------------
// rate_shaped_task_dispatcher_top
// FIFO of task ids that releases at most one id per shaping period.
// ---------------------------------------------------------------------------
// Usage:
//   task channel (task_valid/task_ready/task_data): one word per operation:
//     enqueue, remove, decide or query. Exactly one word comes back on the
//     rsp channel (rsp_valid/rsp_ready/rsp_data) for each word taken.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes shape_period; always
//     ready, write it only while no operation is in flight.
// Sequence (states from accept to DONE, which loads the rsp register):
//   enqueue ENQ; query SUM, CHECK; decide SUM, CHECK, plus SHIFT_RD/SHIFT_WR
//   per entry left behind the head when an id goes out (queue compaction);
//   remove SCAN_RD/SCAN_CMP per entry scanned, none on an empty queue, plus
//   SHIFT_RD/SHIFT_WR per entry moved to close the gap on a match. One queue
//   RAM port pair and one shared time adder carry all of this; the block
//   takes one word at a time.
// Reset: queue empty, shape_period 0, last dispatch time 0, first-run mark
//   set. Queue contents are not cleared.
// Stall: a finished result waits in the rsp register; the next task word
//   may be taken and worked on, and its result is held back until the rsp
//   register is free.
// ---------------------------------------------------------------------------
module rate_shaped_task_dispatcher_top
  import rstd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  task_valid,
  output logic                  task_ready,
  input  task_word_t            task_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_word_t             rsp_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIME_WIDTH-1:0] cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ENQ      = 9'b000000010,
    S_SUM      = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_CMP = 9'b000100000,
    S_SHIFT_RD = 9'b001000000,
    S_SHIFT_WR = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t                state;
  task_word_t            item;          // operation in flight
  rsp_word_t             res;           // result being built
  logic [TIME_WIDTH-1:0] shape_period;
  logic [TIME_WIDTH-1:0] last_assign_time;
  logic                  first_run;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [ACC_W-1:0]      acc;           // last_assign_time + shape_period

  // queue storage
  logic [ID_WIDTH-1:0]   mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]   rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [ID_WIDTH-1:0]   wr_data;
  logic                  mem_we;

  // shared add/subtract unit
  logic [ACC_W-1:0]      unit_a;
  logic [ACC_W-1:0]      unit_b;
  logic                  unit_sub;
  logic [ACC_W-1:0]      unit_sum;

  logic [CNT_W-1:0]      idx_inc;
  logic                  full;
  logic                  diff_le0;
  logic                  eligible;
  logic                  rsp_free;
  rsp_word_t             rsp_next;

  assign task_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign idx_inc    = idx + CNT_W'(1);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign rsp_free   = !rsp_valid || rsp_ready;

  always_comb begin
    unit_a   = acc;
    unit_b   = {2'b00, item.now};
    unit_sub = 1'b1;
    if (state == S_SUM) begin
      unit_a   = {2'b00, last_assign_time};
      unit_b   = {2'b00, shape_period};
      unit_sub = 1'b0;
    end
    unit_sum = unit_a + (unit_b ^ {ACC_W{unit_sub}}) + ACC_W'(unit_sub);
  end

  // in CHECK, unit_sum = next_time - now
  assign diff_le0 = unit_sum[ACC_W-1] || (unit_sum == '0);
  assign eligible = first_run || diff_le0;

  // memory addressing
  always_comb begin
    rd_addr = '0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    mem_we  = 1'b0;
    case (state)
      S_SCAN_RD:  rd_addr = idx[IDX_W-1:0];
      S_SHIFT_RD: rd_addr = idx_inc[IDX_W-1:0];
      S_SHIFT_WR: mem_we  = 1'b1;
      S_ENQ: begin
        wr_addr = count[IDX_W-1:0];
        wr_data = item.task_id;
        mem_we  = !full;
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rsp_next             = res;
    rsp_next.queue_count = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      shape_period     <= '0;
      last_assign_time <= '0;
      first_run        <= 1'b1;
      count            <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shape_period <= cfg_data;
      end
      // rsp register: load a finished result, else release a taken one
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (task_valid) begin
            item <= task_data;
            res  <= '0;
            idx  <= '0;
            case (task_data.func)
              FUNC_ENQUEUE: state <= S_ENQ;
              FUNC_REMOVE:  state <= (count == '0) ? S_DONE : S_SCAN_RD;
              default:      state <= S_SUM;
            endcase
          end
        end
        S_ENQ: begin
          if (full) begin
            res.dropped <= 1'b1;
          end else begin
            count <= count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SUM: begin
          acc   <= unit_sum;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (item.func == FUNC_DECIDE) begin
            if (eligible) begin
              first_run <= 1'b0;
            end
            if (eligible && !item.busy_req && count != '0) begin
              res.assigned      <= 1'b1;
              res.assigned_task <= rd_data;
              last_assign_time  <= item.now;
              idx               <= '0;
              state             <= S_SHIFT_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
            if (!first_run && !diff_le0) begin
              res.slice_valid <= 1'b1;
              res.slice_time  <= unit_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                      : unit_sum[TIME_WIDTH-1:0];
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (rd_data == item.task_id) begin
            res.found <= 1'b1;
            state     <= S_SHIFT_RD;
          end else if (idx_inc < count) begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHIFT_RD: begin
          if (idx_inc < count) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx_inc;
          state <= S_SHIFT_RD;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_data <= rsp_next;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_max, count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `ASSERT_ALWAYS(a_shift_bound, (state != S_SHIFT_WR) || (idx_inc < count), "shift past live entries")
  `ASSERT_NEXT(a_one_at_a_time, task_valid && task_ready, !task_ready, "second word taken while busy")
  `ASSERT_ALWAYS(a_drop_full, !(rsp_valid && rsp_data.dropped) || (rsp_data.queue_count == CNT_W'(QUEUE_DEPTH)), "drop reported with room left")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the rate-shaped task dispatcher. A shadow copy of
// the id queue, the shaping period and the dispatch timestamp predicts each
// response word. Stimulus is a short corner sequence, then random traffic
// under three idle patterns on the task and rsp channels.
// ---------------------------------------------------------------------------
module tb
  import rstd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 8;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  task_valid;
  logic                  task_ready;
  task_word_t            task_data;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_word_t             rsp_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TIME_WIDTH-1:0] cfg_data;

  // idle percentages for the task sender and rsp receiver
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int quiet_cycles;

  // response words still owed by the block, oldest first
  rsp_word_t pending_rsp_words[$];

  // shadow copy of the block state
  logic [ID_WIDTH-1:0]   shadow_ids[$];
  logic [TIME_WIDTH-1:0] shadow_period;
  logic [TIME_WIDTH-1:0] shadow_last;
  bit                    shadow_first;

  // running time base for the random traffic
  logic [TIME_WIDTH-1:0] stim_now;

  rate_shaped_task_dispatcher_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_ready (task_ready),
    .task_data  (task_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor: applies one accepted task word to the shadow state and returns
  // the response word the block owes for it. Time sums carry one extra bit.
  // -------------------------------------------------------------------------
  function automatic rsp_word_t predict_dispatch(task_word_t w);
    rsp_word_t           r;
    logic [TIME_WIDTH:0] release_at;
    logic [TIME_WIDTH:0] wait_left;
    int                  hit;
    r          = '0;
    hit        = -1;
    release_at = {1'b0, shadow_last} + {1'b0, shadow_period};
    case (w.func)
      FUNC_ENQUEUE: begin
        // full queue: id is dropped, queue untouched
        if (shadow_ids.size() >= QUEUE_DEPTH) r.dropped = 1'b1;
        else shadow_ids = {shadow_ids, w.task_id};
      end
      FUNC_REMOVE: begin
        // first match only; the queue closes up behind it
        foreach (shadow_ids[i])
          if (hit < 0 && shadow_ids[i] == w.task_id) hit = i;
        if (hit >= 0) begin
          shadow_ids.delete(hit);
          r.found = 1'b1;
        end
      end
      FUNC_DECIDE: begin
        // first decision always passes the gate and clears the mark,
        // whether or not anything goes out
        if (shadow_first || {1'b0, w.now} >= release_at) begin
          shadow_first = 1'b0;
          if (!w.busy_req && shadow_ids.size() > 0) begin
            r.assigned      = 1'b1;
            r.assigned_task = shadow_ids[0];
            shadow_ids.delete(0);
            shadow_last     = w.now;
          end
        end
      end
      default: begin
        // query: time left, saturated to the time field
        if (!shadow_first && release_at > {1'b0, w.now}) begin
          wait_left     = release_at - {1'b0, w.now};
          r.slice_valid = 1'b1;
          r.slice_time  = wait_left[TIME_WIDTH] ? TIME_MAX : wait_left[TIME_WIDTH-1:0];
        end
      end
    endcase
    r.queue_count = CNT_W'(shadow_ids.size());
    return r;
  endfunction

  function automatic task_word_t make_word(func_t f, logic [ID_WIDTH-1:0] id,
                                          logic [TIME_WIDTH-1:0] t, logic busy);
    task_word_t w;
    w.func     = f;
    w.task_id  = id;
    w.now      = t;
    w.busy_req = busy;
    return w;
  endfunction

  // -------------------------------------------------------------------------
  // Task channel driver. Valid is only lowered inside an idle gap, so a
  // back-to-back word never sees valid dropped and raised in one step.
  // -------------------------------------------------------------------------
  task automatic send_word(task_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      task_valid <= 1'b0;
      @(posedge clk);
    end
    task_valid <= 1'b1;
    task_data  <= w;
    do @(posedge clk); while (!task_ready);
    pending_rsp_words = {pending_rsp_words, predict_dispatch(w)};
  endtask

  // Hold off the sender until every owed response word is back.
  // Always waits on the clock before it checks, so calls never collide in one step.
  task automatic wait_for_results();
    task_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_words.size() != 0);
  endtask

  // Only called with nothing in flight.
  task automatic write_period(logic [TIME_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    shadow_period = value;
  endtask

  // -------------------------------------------------------------------------
  // Corner cases: first-decision rules, empty and full queue, id extremes,
  // busy gate, and the saturating slice with the largest period.
  // -------------------------------------------------------------------------
  task automatic test_directed_corners();
    // period still at its reset value of zero
    send_word(make_word(FUNC_QUERY, 16'h0000, 32'h0, 1'b0));     // no slice before first decide
    send_word(make_word(FUNC_REMOVE, 16'h0005, 32'h0, 1'b0));    // empty queue, no match
    send_word(make_word(FUNC_DECIDE, 16'hFFFF, TIME_MAX, 1'b1)); // first decide, busy, empty
    send_word(make_word(FUNC_QUERY, 16'hFFFF, 32'h0, 1'b1));     // release time not ahead
    // fill the queue with the id extremes at the front, then overflow it
    send_word(make_word(FUNC_ENQUEUE, 16'h0000, 32'h0, 1'b0));
    send_word(make_word(FUNC_ENQUEUE, 16'hFFFF, TIME_MAX, 1'b1));
    repeat (QUEUE_DEPTH - 2)
      send_word(make_word(FUNC_ENQUEUE, ID_WIDTH'($urandom_range(16, 255)), 32'h0, 1'b0));
    send_word(make_word(FUNC_ENQUEUE, 16'h1234, 32'h0, 1'b0));   // dropped
    send_word(make_word(FUNC_REMOVE, 16'hFFFF, 32'h0, 1'b0));    // hit at the second entry
    send_word(make_word(FUNC_DECIDE, 16'h0000, 32'h0, 1'b1));    // gate open but busy
    send_word(make_word(FUNC_DECIDE, 16'h0000, 32'h8000_0000, 1'b0)); // dispatch head
    wait_for_results();
    write_period(TIME_MAX);
    send_word(make_word(FUNC_QUERY, 16'h0000, 32'h0, 1'b0));     // slice saturates
    send_word(make_word(FUNC_QUERY, 16'h0000, TIME_MAX, 1'b0));  // slice fits
    send_word(make_word(FUNC_DECIDE, 16'h0000, TIME_MAX, 1'b0)); // gate stays shut
  endtask

  // -------------------------------------------------------------------------
  // Random traffic. Time mostly advances from a running base so the shaping
  // gate opens and shuts; a few words carry a fully random time. A random
  // time on a decide is sent busy so it cannot move the dispatch timestamp
  // out of reach of the rest of the phase.
  // -------------------------------------------------------------------------
  task automatic run_random_traffic(int count, int s_pct, int r_pct,
                                    logic [TIME_WIDTH-1:0] period);
    task_word_t            w;
    int                    n;
    int                    pick;
    int                    enq_weight;
    logic [TIME_WIDTH-1:0] step_max;
    wait_for_results();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_period(period);
    stim_now   = shadow_last;
    step_max   = (period >> 2) + 3;
    enq_weight = 40;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        // sender stops until the block has handed back everything
        if (n != 0) wait_for_results();
        // shift the mix between filling and draining the queue
        enq_weight = $urandom_range(20, 60);
      end
      stim_now += $urandom_range(0, step_max);
      pick = $urandom_range(99);
      if (pick < enq_weight) w.func = FUNC_ENQUEUE;
      else if (pick < enq_weight + 15) w.func = FUNC_REMOVE;
      else if (pick < 85) w.func = FUNC_DECIDE;
      else w.func = FUNC_QUERY;
      if ($urandom_range(4) == 0)
        w.task_id = ID_WIDTH'($urandom_range(0, 16'hFFFF));
      else if (w.func == FUNC_REMOVE && shadow_ids.size() > 0 && $urandom_range(3) != 0)
        w.task_id = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
      else
        w.task_id = ID_WIDTH'($urandom_range(0, 15));
      w.busy_req = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) begin
        w.now = $urandom();
        if (w.func == FUNC_DECIDE) w.busy_req = 1'b1;
      end else begin
        w.now = stim_now;
      end
      send_word(w);
    end
  endtask

  // -------------------------------------------------------------------------
  // Response checker: every accepted rsp word against the oldest owed one.
  // -------------------------------------------------------------------------
  task automatic check_field(string name, logic [TIME_WIDTH-1:0] got,
                             logic [TIME_WIDTH-1:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp_words.size() == 0) begin
        mismatches++;
        $display("%0t: rsp word with none owed: expected nothing, actual 0x%0h",
                 $time, rsp_data);
      end else begin
        want = pending_rsp_words[0];
        pending_rsp_words.delete(0);
        check_field("assigned", rsp_data.assigned, want.assigned);
        check_field("assigned_task", rsp_data.assigned_task, want.assigned_task);
        check_field("slice_valid", rsp_data.slice_valid, want.slice_valid);
        check_field("slice_time", rsp_data.slice_time, want.slice_time);
        check_field("dropped", rsp_data.dropped, want.dropped);
        check_field("found", rsp_data.found, want.found);
        check_field("queue_count", rsp_data.queue_count, want.queue_count);
      end
    end
  end

  // rsp backpressure
  always @(posedge clk)
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (rst || (task_valid && task_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst        <= 1'b1;
    task_valid <= 1'b0;
    task_data  <= '0;
    rsp_ready  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    quiet_cycles  = 0;
    mismatches    = 0;
    send_idle_pct = 36;
    recv_idle_pct = 87;
    shadow_period = '0;
    shadow_last   = '0;
    shadow_first  = 1'b1;
    stim_now      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    // sender lightly idle, receiver mostly stalled
    run_random_traffic(250, 36, 87, TIME_WIDTH'($urandom_range(4, 40)));
    // the other way round, no shaping at all
    run_random_traffic(200, 87, 36, '0);
    // no idling: long period, then a short one
    run_random_traffic(60, 0, 0, TIME_WIDTH'($urandom_range(32'h0010_0000, 32'h0100_0000)));
    run_random_traffic(200, 0, 0, TIME_WIDTH'($urandom_range(1, 20)));

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/rstd_pkg.sv
src/rate_shaped_task_dispatcher_top.sv
verif/tb.sv
